// ===== hdl/rsz_pkg.sv =====
// rsz_pkg: shared types, widths and constants of the bilinear resize block
// no dependencies; imported by every module of the block
package rsz_pkg;

    // fixed-point format
    localparam int FRAC_BITS    = 10;
    localparam int WEIGHT_SHIFT = 12;
    localparam int SUM_SHIFT    = 8;
    localparam logic [FRAC_BITS-1:0] FRAC_MASK = FRAC_BITS'((1 << FRAC_BITS) - 1);

    // field widths
    localparam int SIZE_SRC_W = 9;
    localparam int SIZE_DST_W = 13;
    localparam int COORD_W    = 12;
    localparam int SADDR_W    = 16;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // step ratio, source position, neighbour address, accumulator and divider count widths
    localparam int STEP_W      = SIZE_SRC_W + FRAC_BITS;
    localparam int POS_W       = SIZE_SRC_W + FRAC_BITS;
    localparam int ADDR_CALC_W = 2 * SIZE_SRC_W + 1;
    localparam int ACC_W       = 2 * CH_W + 2;
    localparam int DIV_CNT_W   = $clog2(STEP_W + 1);

    // neighbour sequencing
    localparam int NEIGHBOURS = 4;
    localparam int NB_W       = $clog2(NEIGHBOURS);
    localparam logic [NB_W-1:0] NB_LAST = NB_W'(NEIGHBOURS - 1);

    // reset geometry and the step ratio it implies
    localparam int RESET_SRC_SIZE = 256;
    localparam int RESET_DST_SIZE = 256;
    localparam logic [STEP_W-1:0] STEP_RESET =
        STEP_W'((RESET_SRC_SIZE << FRAC_BITS) / RESET_DST_SIZE);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } cfg_idx_t;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic            load_query;
        logic            calc_mul;
        logic            calc_base;
        logic            calc_addr;
        logic            wr_en;
        logic            rd_en;
        logic [NB_W-1:0] rd_sel;
        logic            mac_en;
        logic            out_load;
    } rsz_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_busy;
        logic coord_bad;
        logic addr_bad;
        logic out_free;
    } rsz_status_t;

endpackage

// ===== hdl/rsz_div.sv =====
// rsz_div: restoring divider, one quotient bit per cycle, for the step ratio
// depends on rsz_pkg
module rsz_div
    import rsz_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [STEP_W-1:0]     num,
    input  logic [SIZE_DST_W-1:0] den,
    output logic                  busy,
    output logic [STEP_W-1:0]     quo
);

    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [STEP_W-1:0]     work_reg;
    logic [SIZE_DST_W-1:0] rem_reg;
    logic [SIZE_DST_W-1:0] den_reg;
    logic [STEP_W-1:0]     quo_reg;

    logic [SIZE_DST_W:0]   trial;
    logic [SIZE_DST_W:0]   diff;
    logic                  qbit;
    logic [SIZE_DST_W-1:0] rem_next;
    logic [STEP_W-1:0]     work_next;

    // trial subtraction of one step
    always_comb
    begin
        trial     = {rem_reg, work_reg[STEP_W-1]};
        diff      = trial - {1'b0, den_reg};
        qbit      = (trial >= {1'b0, den_reg});
        rem_next  = qbit ? diff[SIZE_DST_W-1:0] : trial[SIZE_DST_W-1:0];
        work_next = {work_reg[STEP_W-2:0], qbit};
    end

    // iteration count and finished quotient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            quo_reg <= STEP_RESET;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(STEP_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                quo_reg <= work_next;
            end
        end
    end

    // shifting dividend and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num;
            den_reg  <= den;
            rem_reg  <= '0;
        end
        else if (cnt_reg != '0)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;

endmodule

// ===== hdl/rsz_dp.sv =====
// rsz_dp: datapath with geometry registers, step dividers, source memory,
// neighbour address and weight logic, channel accumulators and output register
// depends on rsz_pkg and rsz_div
module rsz_dp
    import rsz_pkg::*;
#(
    parameter int unsigned SRC_PIXELS = 65536
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rsz_cmd_t              cmd,
    output rsz_status_t           status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [SADDR_W-1:0]    src_addr,
    input  logic [PIX_W-1:0]      src_pixel,
    input  logic [COORD_W-1:0]    dst_x,
    input  logic [COORD_W-1:0]    dst_y,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      out_pixel,
    output logic                  bad_query
);

    localparam int AW = (SRC_PIXELS > 1) ? $clog2(SRC_PIXELS) : 1;

    // geometry registers
    logic [SIZE_SRC_W-1:0] src_w_reg;
    logic [SIZE_SRC_W-1:0] src_h_reg;
    logic [SIZE_DST_W-1:0] dst_w_reg;
    logic [SIZE_DST_W-1:0] dst_h_reg;
    logic                  cfg_wr_d_reg;

    // step ratios
    logic [STEP_W-1:0] step_x_q;
    logic [STEP_W-1:0] step_y_q;
    logic              busy_x;
    logic              busy_y;

    // query pipeline
    logic [COORD_W-1:0]     u_reg;
    logic [COORD_W-1:0]     v_reg;
    logic [POS_W-1:0]       su_reg;
    logic [POS_W-1:0]       sv_reg;
    logic                   bad_reg;
    logic [ADDR_CALC_W-1:0] base_reg;
    logic                   step_x_reg;
    logic [SIZE_SRC_W-1:0]  step_y_reg;

    // neighbour read and accumulate
    logic [PIX_W-1:0] mem [SRC_PIXELS];
    logic [PIX_W-1:0] rd_data_reg;
    logic [CH_W-1:0]  w_reg;
    logic [ACC_W-1:0] acc_r_reg;
    logic [ACC_W-1:0] acc_g_reg;
    logic [ACC_W-1:0] acc_b_reg;

    // output register
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic             bad_query_reg;

    // combinational helpers
    logic [COORD_W+STEP_W-1:0]  su_full;
    logic [COORD_W+STEP_W-1:0]  sv_full;
    logic                       coord_bad_next;
    logic [SIZE_SRC_W-1:0]      ux_int;
    logic [SIZE_SRC_W-1:0]      vy_int;
    logic [2*SIZE_SRC_W-1:0]    row_off;
    logic [POS_W:0]             x_reach;
    logic [POS_W:0]             y_reach;
    logic [POS_W-1:0]           x_limit;
    logic [POS_W-1:0]           y_limit;
    logic [ADDR_CALC_W-1:0]     base_next;
    logic [ADDR_CALC_W-1:0]     last_addr;
    logic                       addr_bad;
    logic [ADDR_CALC_W-1:0]     rd_addr;
    logic [31:0]                rd_addr32;
    logic [31:0]                wr_addr32;
    logic                       wr_in_range;
    logic [FRAC_BITS-1:0]       fu;
    logic [FRAC_BITS-1:0]       fv;
    logic [2*FRAC_BITS-1:0]     w_prod;
    logic [2*CH_W-1:0]          prod_r;
    logic [2*CH_W-1:0]          prod_g;
    logic [2*CH_W-1:0]          prod_b;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg    <= SIZE_SRC_W'(RESET_SRC_SIZE);
            src_h_reg    <= SIZE_SRC_W'(RESET_SRC_SIZE);
            dst_w_reg    <= SIZE_DST_W'(RESET_DST_SIZE);
            dst_h_reg    <= SIZE_DST_W'(RESET_DST_SIZE);
            cfg_wr_d_reg <= 1'b0;
        end
        else
        begin
            cfg_wr_d_reg <= cfg_we;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_SRC_WIDTH:  src_w_reg <= cfg_data[SIZE_SRC_W-1:0];
                    CFG_SRC_HEIGHT: src_h_reg <= cfg_data[SIZE_SRC_W-1:0];
                    CFG_DST_WIDTH:  dst_w_reg <= cfg_data[SIZE_DST_W-1:0];
                    CFG_DST_HEIGHT: dst_h_reg <= cfg_data[SIZE_DST_W-1:0];
                endcase
            end
        end
    end

    // step ratio per axis, recomputed after every register write
    rsz_div u_div_x
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_wr_d_reg),
        .num   ({src_w_reg, {FRAC_BITS{1'b0}}}),
        .den   (dst_w_reg),
        .busy  (busy_x),
        .quo   (step_x_q)
    );

    rsz_div u_div_y
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_wr_d_reg),
        .num   ({src_h_reg, {FRAC_BITS{1'b0}}}),
        .den   (dst_h_reg),
        .busy  (busy_y),
        .quo   (step_y_q)
    );

    // source position and coordinate check
    always_comb
    begin
        su_full        = u_reg * step_x_q;
        sv_full        = v_reg * step_y_q;
        coord_bad_next = ({1'b0, u_reg} >= dst_w_reg) || ({1'b0, v_reg} >= dst_h_reg) ||
                         (src_w_reg == '0) || (src_h_reg == '0);
    end

    // top-left neighbour and edge steps
    always_comb
    begin
        ux_int    = su_reg[POS_W-1:FRAC_BITS];
        vy_int    = sv_reg[POS_W-1:FRAC_BITS];
        row_off   = vy_int * src_w_reg;
        base_next = ADDR_CALC_W'(ux_int) + ADDR_CALC_W'(row_off);
        x_reach   = {1'b0, su_reg} + {1'b0, step_x_q};
        y_reach   = {1'b0, sv_reg} + {1'b0, step_y_q};
        x_limit   = {SIZE_SRC_W'(src_w_reg - SIZE_SRC_W'(1)), {FRAC_BITS{1'b0}}};
        y_limit   = {SIZE_SRC_W'(src_h_reg - SIZE_SRC_W'(1)), {FRAC_BITS{1'b0}}};
    end

    // farthest neighbour decides the memory bound check
    always_comb
    begin
        last_addr = base_reg + ADDR_CALC_W'(step_y_reg) + ADDR_CALC_W'(step_x_reg);
        addr_bad  = (32'(last_addr) >= SRC_PIXELS);
    end

    // neighbour address and weight for the selected read
    always_comb
    begin
        rd_addr   = base_reg +
                    (cmd.rd_sel[1] ? ADDR_CALC_W'(step_y_reg) : '0) +
                    (cmd.rd_sel[0] ? ADDR_CALC_W'(step_x_reg) : '0);
        rd_addr32 = 32'(rd_addr);
        fu        = cmd.rd_sel[0] ? su_reg[FRAC_BITS-1:0] : FRAC_MASK - su_reg[FRAC_BITS-1:0];
        fv        = cmd.rd_sel[1] ? sv_reg[FRAC_BITS-1:0] : FRAC_MASK - sv_reg[FRAC_BITS-1:0];
        w_prod    = fu * fv;
    end

    // write address check
    always_comb
    begin
        wr_addr32   = 32'(src_addr);
        wr_in_range = (wr_addr32 < SRC_PIXELS);
    end

    // per-channel products of the previous read
    always_comb
    begin
        prod_r = rd_data_reg[2*CH_W +: CH_W] * w_reg;
        prod_g = rd_data_reg[CH_W +: CH_W] * w_reg;
        prod_b = rd_data_reg[0 +: CH_W] * w_reg;
    end

    // query pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            u_reg <= dst_x;
            v_reg <= dst_y;
        end
        if (cmd.calc_mul)
        begin
            su_reg  <= su_full[POS_W-1:0];
            sv_reg  <= sv_full[POS_W-1:0];
            bad_reg <= coord_bad_next;
        end
        if (cmd.calc_base)
        begin
            base_reg   <= base_next;
            step_x_reg <= !(x_reach > {1'b0, x_limit});
            step_y_reg <= (y_reach > {1'b0, y_limit}) ? '0 : src_w_reg;
        end
        if (cmd.calc_addr)
        begin
            bad_reg   <= bad_reg | addr_bad;
            acc_r_reg <= '0;
            acc_g_reg <= '0;
            acc_b_reg <= '0;
        end
        if (cmd.rd_en)
        begin
            w_reg <= w_prod[WEIGHT_SHIFT +: CH_W];
        end
        if (cmd.mac_en)
        begin
            acc_r_reg <= acc_r_reg + ACC_W'(prod_r);
            acc_g_reg <= acc_g_reg + ACC_W'(prod_g);
            acc_b_reg <= acc_b_reg + ACC_W'(prod_b);
        end
    end

    // source memory, single port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_in_range)
        begin
            mem[wr_addr32[AW-1:0]] <= src_pixel;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr32[AW-1:0]];
        end
    end

    // output register handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            bad_query_reg <= bad_reg;
            out_pixel_reg <= bad_reg ? '0 : {acc_r_reg[SUM_SHIFT +: CH_W],
                                             acc_g_reg[SUM_SHIFT +: CH_W],
                                             acc_b_reg[SUM_SHIFT +: CH_W]};
        end
    end

    // status to the controller
    always_comb
    begin
        status.div_busy  = cfg_we || cfg_wr_d_reg || busy_x || busy_y;
        status.coord_bad = bad_reg;
        status.addr_bad  = addr_bad;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign bad_query = bad_query_reg;

endmodule

// ===== hdl/rsz_ctrl.sv =====
// rsz_ctrl: state machine that sequences writes and queries through the datapath
// depends on rsz_pkg
module rsz_ctrl
    import rsz_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        req_type,
    output logic        in_stall,
    input  rsz_status_t status,
    output rsz_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_BASE = 7'b0000100,
        S_ADDR = 7'b0001000,
        S_READ = 7'b0010000,
        S_MAC  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [NB_W-1:0] nb_cnt_reg;
    logic [NB_W-1:0] nb_cnt_next;
    logic            in_accept;

    // input side takes requests only when idle and the step ratios are settled
    assign in_stall  = (state_reg != S_IDLE) || status.div_busy;
    assign in_accept = in_valid && !in_stall;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        nb_cnt_next = nb_cnt_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type == REQ_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = S_MUL;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                cmd.calc_mul = 1'b1;
                state_next   = S_BASE;
            end
            S_BASE:
            begin
                cmd.calc_base = 1'b1;
                state_next    = status.coord_bad ? S_OUT : S_ADDR;
            end
            S_ADDR:
            begin
                cmd.calc_addr = 1'b1;
                nb_cnt_next   = '0;
                state_next    = status.addr_bad ? S_OUT : S_READ;
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = nb_cnt_reg;
                cmd.mac_en = (nb_cnt_reg != '0);
                if (nb_cnt_reg == NB_LAST)
                begin
                    state_next = S_MAC;
                end
                else
                begin
                    nb_cnt_next = nb_cnt_reg + NB_W'(1);
                end
            end
            S_MAC:
            begin
                cmd.mac_en = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            nb_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            nb_cnt_reg <= nb_cnt_next;
        end
    end

endmodule

// ===== hdl/bilinear_image_resize.sv =====
// bilinear_image_resize: top level of the bilinear RGB888 resize block
// depends on rsz_pkg, rsz_ctrl, rsz_dp (and rsz_div through rsz_dp)
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  req_type src_addr src_pixel dst_x dst_y
//   output    out        out_valid / out_stall out_pixel bad_query
//   config    in         cfg_we               cfg_index cfg_data
//
// a source write is stored as it is accepted; a query holds the input side through:
// accept, position multiply, base address, bound check, four neighbour reads on
// the single-port source memory, last accumulate, load of the output register once free
// each config write restarts both step dividers; input stalls from the write until both end
// rejected queries skip the reads and go straight to the output register load
// reset sets control state and the reset geometry; source memory is undefined until written
// a finished result waits in the output register while the next request enters
module bilinear_image_resize
    import rsz_pkg::*;
#(
    parameter int unsigned SRC_PIXELS = 65536
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [SADDR_W-1:0]    src_addr,
    input  logic [PIX_W-1:0]      src_pixel,
    input  logic [COORD_W-1:0]    dst_x,
    input  logic [COORD_W-1:0]    dst_y,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      out_pixel,
    output logic                  bad_query,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    rsz_cmd_t    cmd;
    rsz_status_t status;

    // sequencer
    rsz_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    rsz_dp #(
        .SRC_PIXELS (SRC_PIXELS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_addr  (src_addr),
        .src_pixel (src_pixel),
        .dst_x     (dst_x),
        .dst_y     (dst_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pixel (out_pixel),
        .bad_query (bad_query)
    );

endmodule

// ===== hdl/rsz_chk.sv =====
// rsz_chk: port-level checks of the resize block, bound to the top level
// depends on rsz_pkg and bilinear_image_resize
module rsz_chk
    import rsz_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  req_type,
    input logic [SADDR_W-1:0]    src_addr,
    input logic [PIX_W-1:0]      src_pixel,
    input logic [COORD_W-1:0]    dst_x,
    input logic [COORD_W-1:0]    dst_y,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [PIX_W-1:0]      out_pixel,
    input logic                  bad_query,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_pixel) && $stable(bad_query))
        else $error("stalled result changed");

    // rejected queries carry a zero pixel
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_query |-> out_pixel == '0)
        else $error("rejected query with nonzero pixel");

    // a query occupies the block after it is taken
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type == REQ_QUERY |=> in_stall)
        else $error("request taken while a query is in progress");

    // no result can be ready the cycle after a request is taken
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared right after a request");

endmodule

bind bilinear_image_resize rsz_chk u_rsz_chk (.*);

// ===== tb/bilinear_image_resize_tb.sv =====
// bilinear_image_resize_tb: self-checking testbench of the bilinear RGB888 resize block
// depends on rsz_pkg and bilinear_image_resize; a local resampler predicts each query
// result while random idling on both channels and geometry changes exercise the control
`timescale 1ns / 1ps

module bilinear_image_resize_tb;

    import rsz_pkg::*;

    localparam int  SRC_DEPTH     = 65536;
    localparam int  SETTLE_CYCLES = 30;
    localparam int  CFG_GAP       = 24;
    localparam longint CYCLE_LIMIT = 800000;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             bad;
    } resample_t;

    // source entries one query reads; reads is low when the query is rejected first
    typedef struct packed {
        logic                        reads;
        logic [NEIGHBOURS-1:0][31:0] addr;
    } nb_list_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic                  req_type  = REQ_WRITE;
    logic [SADDR_W-1:0]    src_addr  = '0;
    logic [PIX_W-1:0]      src_pixel = '0;
    logic [COORD_W-1:0]    dst_x     = '0;
    logic [COORD_W-1:0]    dst_y     = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIX_W-1:0]      out_pixel;
    logic                  bad_query;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_SRC_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // local copy of the source image and the geometry registers
    logic [PIX_W-1:0]      source_mirror [SRC_DEPTH];
    bit                    written [SRC_DEPTH];
    logic [SIZE_SRC_W-1:0] geo_src_w = 9'd256;
    logic [SIZE_SRC_W-1:0] geo_src_h = 9'd256;
    logic [SIZE_DST_W-1:0] geo_dst_w = 13'd256;
    logic [SIZE_DST_W-1:0] geo_dst_h = 13'd256;

    resample_t pending_pixels [$];
    resample_t oldest;

    int     mismatch_count = 0;
    int     items_sent     = 0;
    int     writes_sent    = 0;
    int     queries_sent   = 0;
    int     rejected_count = 0;
    int     results_seen   = 0;
    int     geometry_count = 0;
    int     stall_hold     = 0;
    bit     quiet          = 1'b0;
    longint cycle_count    = 0;

    bilinear_image_resize u_dut (.*);

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_pixels.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    always @(posedge clk)
    begin
        if (quiet)
            out_stall <= 1'b0;
        else if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_hold <= $urandom_range(0, 8);
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // result checker against the oldest pending query
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_pixels.size() == 0)
                report_mismatch($sformatf("result with no query pending: pixel %06h bad %0b",
                                          out_pixel, bad_query));
            else
            begin
                oldest = pending_pixels.pop_front();
                if (out_pixel !== oldest.pixel)
                    report_mismatch($sformatf("out_pixel %06h, predicted %06h",
                                              out_pixel, oldest.pixel));
                if (bad_query !== oldest.bad)
                    report_mismatch($sformatf("bad_query %0b, predicted %0b",
                                              bad_query, oldest.bad));
            end
        end
    end

    // bilinear resample of one destination pixel from the mirrored source image
    function automatic resample_t resample_pixel(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
        longint unsigned sw, sh, step_u, step_v, pos_u, pos_v, fu, fv;
        longint unsigned inc_x, inc_y, base, acc, fmax;
        longint unsigned nb_addr [NEIGHBOURS];
        longint unsigned wt [NEIGHBOURS];
        logic [PIX_W-1:0] nb [NEIGHBOURS];
        resample_t r;
        int i;
        int c;
        r.pixel = '0;
        r.bad   = 1'b1;
        sw      = geo_src_w;
        sh      = geo_src_h;
        fmax    = FRAC_MASK;
        if (x >= geo_dst_w || y >= geo_dst_h || sw == 0 || sh == 0)
            return r;

        step_u = (sw << FRAC_BITS) / geo_dst_w;
        step_v = (sh << FRAC_BITS) / geo_dst_h;
        pos_u  = x * step_u;
        pos_v  = y * step_v;
        fu     = pos_u & fmax;
        fv     = pos_v & fmax;

        wt[0] = ((fmax - fu) * (fmax - fv)) >> WEIGHT_SHIFT;
        wt[1] = (fu * (fmax - fv)) >> WEIGHT_SHIFT;
        wt[2] = ((fmax - fu) * fv) >> WEIGHT_SHIFT;
        wt[3] = (fu * fv) >> WEIGHT_SHIFT;

        // right and bottom edges reuse the same column or row
        inc_x = (pos_u + step_u > ((sw - 1) << FRAC_BITS)) ? 0 : 1;
        inc_y = (pos_v + step_v > ((sh - 1) << FRAC_BITS)) ? 0 : sw;
        base  = (pos_u >> FRAC_BITS) + (pos_v >> FRAC_BITS) * sw;
        nb_addr[0] = base;
        nb_addr[1] = base + inc_x;
        nb_addr[2] = base + inc_y;
        nb_addr[3] = base + inc_y + inc_x;

        // any neighbour beyond the source memory rejects the query
        for (i = 0; i < NEIGHBOURS; i++)
        begin
            if (nb_addr[i] >= SRC_DEPTH)
                return r;
            nb[i] = source_mirror[nb_addr[i]];
        end

        for (c = 0; c < 3; c++)
        begin
            acc = 0;
            for (i = 0; i < NEIGHBOURS; i++)
                acc += nb[i][c*CH_W +: CH_W] * wt[i];
            r.pixel[c*CH_W +: CH_W] = acc >> SUM_SHIFT;
        end
        r.bad = 1'b0;
        return r;
    endfunction

    // source entries a query reads under the current geometry
    function automatic nb_list_t query_reads(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
        longint unsigned sw, sh, step_u, step_v, pos_u, pos_v, inc_x, inc_y, base;
        nb_list_t nl;
        int i;
        nl = '0;
        sw = geo_src_w;
        sh = geo_src_h;
        if (x >= geo_dst_w || y >= geo_dst_h || sw == 0 || sh == 0)
            return nl;

        step_u = (sw << FRAC_BITS) / geo_dst_w;
        step_v = (sh << FRAC_BITS) / geo_dst_h;
        pos_u  = x * step_u;
        pos_v  = y * step_v;
        inc_x  = (pos_u + step_u > ((sw - 1) << FRAC_BITS)) ? 0 : 1;
        inc_y  = (pos_v + step_v > ((sh - 1) << FRAC_BITS)) ? 0 : sw;
        base   = (pos_u >> FRAC_BITS) + (pos_v >> FRAC_BITS) * sw;
        nl.addr[0] = 32'(base);
        nl.addr[1] = 32'(base + inc_x);
        nl.addr[2] = 32'(base + inc_y);
        nl.addr[3] = 32'(base + inc_y + inc_x);

        // a neighbour beyond the memory means nothing is read at all
        nl.reads = 1'b1;
        for (i = 0; i < NEIGHBOURS; i++)
        begin
            if (nl.addr[i] >= SRC_DEPTH)
                nl.reads = 1'b0;
        end
        return nl;
    endfunction

    // one request on the input channel, with an optional idle burst ahead of it
    task automatic send_request(input logic kind, input logic [SADDR_W-1:0] addr,
                                input logic [PIX_W-1:0] pix, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y);
        resample_t r;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_type  <= kind;
        src_addr  <= addr;
        src_pixel <= pix;
        dst_x     <= x;
        dst_y     <= y;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);

        // request accepted: update the mirror or predict the result
        items_sent++;
        if (kind == REQ_WRITE)
        begin
            source_mirror[addr] = pix;
            written[addr]       = 1'b1;
            writes_sent++;
        end
        else
        begin
            r = resample_pixel(x, y);
            pending_pixels.push_back(r);
            queries_sent++;
            if (r.bad)
                rejected_count++;
        end
    endtask

    task automatic send_write(input logic [SADDR_W-1:0] addr, input logic [PIX_W-1:0] pix);
        send_request(REQ_WRITE, addr, pix, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // entries the query will read get a value first
    task automatic send_query(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        nb_list_t nl;
        int i;
        nl = query_reads(x, y);
        if (nl.reads)
        begin
            for (i = 0; i < NEIGHBOURS; i++)
            begin
                if (!written[nl.addr[i]])
                    send_write(SADDR_W'(nl.addr[i]), PIX_W'($urandom));
            end
        end
        send_request(REQ_QUERY, SADDR_W'($urandom), PIX_W'($urandom), x, y);
    endtask

    // stop sending, let every pending result arrive and the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        // the step dividers restart on every write
        repeat (CFG_GAP) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] sw, input logic [CFG_DATA_W-1:0] sh,
                                input logic [CFG_DATA_W-1:0] dw, input logic [CFG_DATA_W-1:0] dh);
        wait_idle();
        write_register(CFG_SRC_WIDTH, sw);
        write_register(CFG_SRC_HEIGHT, sh);
        write_register(CFG_DST_WIDTH, dw);
        write_register(CFG_DST_HEIGHT, dh);
        geo_src_w = sw[SIZE_SRC_W-1:0];
        geo_src_h = sh[SIZE_SRC_W-1:0];
        geo_dst_w = dw;
        geo_dst_h = dh;
        geometry_count++;
    endtask

    // destination coordinate: mostly inside the image, some on its far edge, some anywhere
    function automatic logic [COORD_W-1:0] pick_coord(input int size);
        int roll;
        int span;
        roll = $urandom_range(0, 9);
        span = (size > 4096) ? 4096 : size;
        if (size == 0 || roll == 0)
            return COORD_W'($urandom);
        if (roll == 1)
            return COORD_W'(span - 1);
        return COORD_W'($urandom_range(0, span - 1));
    endfunction

    // random mix of source writes and queries for the current geometry
    task automatic random_traffic(input int count, input int write_pct);
        int stop;
        int region;
        stop   = items_sent + count;
        region = int'(geo_src_w) * int'(geo_src_h);
        if (region == 0 || region > SRC_DEPTH)
            region = SRC_DEPTH;
        while (items_sent < stop)
        begin
            if ($urandom_range(0, 99) < write_pct)
                send_write(SADDR_W'($urandom_range(0, region - 1)), PIX_W'($urandom));
            else
                send_query(pick_coord(geo_dst_w), pick_coord(geo_dst_h));
        end
    endtask

    // corners, edges, rejections and zero sizes
    task automatic test_directed();
        // reset geometry, unit step
        send_write(16'd0, 24'hFFFFFF);
        send_write(16'd1, 24'h000000);
        send_write(16'd256, 24'h123456);
        send_write(16'hFFFF, 24'h000000);
        send_query(12'd0, 12'd0);
        send_query(12'd255, 12'd255);
        send_query(12'd255, 12'd0);
        send_query(12'd0, 12'd255);
        send_query(12'd256, 12'd0);
        send_query(12'd0, 12'd256);
        send_query(12'hFFF, 12'hFFF);
        send_query(12'hFFF, 12'd0);

        // fractional steps
        set_geometry(13'd256, 13'd256, 13'd1000, 13'd700);
        send_query(12'd999, 12'd699);
        send_query(12'd1, 12'd1);
        send_query(12'd500, 12'd350);

        // zero source width through the register mask, zero height, zero destination
        set_geometry(13'h0200, 13'd256, 13'd256, 13'd256);
        send_query(12'd0, 12'd0);
        set_geometry(13'd256, 13'd0, 13'd256, 13'd256);
        send_query(12'd0, 12'd0);
        set_geometry(13'd256, 13'd256, 13'd0, 13'd0);
        send_query(12'd0, 12'd0);

        // large source geometry: neighbours inside and beyond the source memory
        set_geometry(13'h1FFF, 13'h1FFF, 13'd300, 13'd300);
        send_query(12'd299, 12'd299);
        send_query(12'd0, 12'd0);
        send_query(12'd150, 12'd150);
    endtask

    // random traffic over a spread of geometries, extremes first
    task automatic test_geometry_sweep();
        int k;
        set_geometry(13'd1, 13'd1, 13'd1, 13'd1);
        random_traffic(80, 20);
        set_geometry(13'd256, 13'd256, 13'd4096, 13'd4096);
        random_traffic(130, 20);
        set_geometry(13'd256, 13'd256, 13'd16, 13'd16);
        random_traffic(130, 20);
        set_geometry(13'd1, 13'd256, 13'd2048, 13'd3);
        random_traffic(100, 20);
        set_geometry(13'h1FFF, 13'h1FFF, 13'd100, 13'd100);
        random_traffic(100, 20);
        set_geometry(13'd40, 13'd30, 13'h1FFF, 13'h1FFF);
        random_traffic(100, 20);
        for (k = 0; k < 5; k++)
        begin
            set_geometry(CFG_DATA_W'($urandom_range(1, 256)), CFG_DATA_W'($urandom_range(1, 256)),
                         CFG_DATA_W'($urandom_range(1, 4096)),
                         CFG_DATA_W'($urandom_range(1, 4096)));
            random_traffic(120, 20);
        end
    endtask

    // sender holds off until the block has returned everything
    task automatic test_pause_for_results();
        int k;
        set_geometry(13'd200, 13'd150, 13'd300, 13'd225);
        for (k = 0; k < 8; k++)
        begin
            random_traffic(10, 20);
            in_valid <= 1'b0;
            while (pending_pixels.size() != 0)
                @(posedge clk);
        end
    endtask

    // back-to-back requests with no idling on either side
    task automatic test_closing_burst();
        set_geometry(13'd256, 13'd256, 13'd333, 13'd777);
        quiet = 1'b1;
        random_traffic(200, 15);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_geometry_sweep();
        test_pause_for_results();
        test_closing_burst();
        wait_idle();

        $display("%0d source writes, %0d queries (%0d rejected), %0d results checked",
                 writes_sent, queries_sent, rejected_count, results_seen);
        $display("%0d geometry settings, %0d mismatches", geometry_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
